### hdl/nfc_response_frame_parser_macros.svh
// ---------------------------------------------------------------------------
// NFC response frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef NFC_RESPONSE_FRAME_PARSER_MACROS_SVH
`define NFC_RESPONSE_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define NFCRP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nfcrp assertion failed");

// next-cycle implication
`define NFCRP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nfcrp assertion failed");

`endif

### hdl/nfcrp_pkg.sv
// ---------------------------------------------------------------------------
// NFC response frame parser package
// Types and constants shared by the parser modules.
// ---------------------------------------------------------------------------
package nfcrp_pkg;

  localparam int BYTE_W = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_INDEX_W = 1;

  localparam logic [BYTE_W-1:0] HDR_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] HDR_START = 8'hFF;
  localparam logic [BYTE_W-1:0] FRAME_ID_RESPONSE = 8'hD5;
  localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd2;

  localparam logic [BYTE_W-1:0] RESET_EXPECTED_CODE = 8'd0;
  localparam logic [BYTE_W-1:0] RESET_PAYLOAD_CAPACITY = 8'd255;

  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_CODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_CAPACITY = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_LCS    = 3'd2,
    ST_UNEXPECTED = 3'd3,
    ST_TOO_LARGE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    POS_PRE0  = 3'd0,
    POS_PRE1  = 3'd1,
    POS_START = 3'd2,
    POS_LEN   = 3'd3,
    POS_LCS   = 3'd4,
    POS_TFI   = 3'd5,
    POS_CODE  = 3'd6,
    POS_DATA  = 3'd7
  } pos_t;

  typedef struct packed {
    logic              frame_start;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic              has_data;
    logic [BYTE_W-1:0] payload_byte;
    status_t           status;
    logic              last;
  } result_t;

endpackage

### hdl/nfc_response_frame_parser.sv
// ---------------------------------------------------------------------------
// NFC response frame parser
// Checks the header, length checksum, identifier and response code of a
// received frame and streams out its payload bytes or one status beat.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata = rx_byte, s_tuser = frame_start
// m_axis    out  m_tvalid/m_tready  m_tdata = payload_byte,
//                                   m_tuser = {status, has_data}, m_tlast
// cfg       in   cfg_we             cfg_addr, cfg_wdata
//
// One byte per cycle sustained while no result waits on m_tready; a result
// passes through the input register and then the result register.
// Bytes that give no result pass through without waiting on m_tready.
// rst clears both registers and leaves the parser idle until frame_start.
// ---------------------------------------------------------------------------
module nfc_response_frame_parser
  import nfcrp_pkg::*;
#(
  parameter logic [BYTE_W-1:0] EXPECTED_CODE_RESET = RESET_EXPECTED_CODE,
  parameter logic [BYTE_W-1:0] CAPACITY_RESET      = RESET_PAYLOAD_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [BYTE_W-1:0]        s_tdata,   // [7:0] rx_byte
  input  logic                     s_tuser,   // [0] frame_start
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [BYTE_W-1:0]        m_tdata,   // [7:0] payload_byte
  output logic [STATUS_W:0]        m_tuser,   // [0] has_data, [3:1] status
  output logic                     m_tlast,
  input  logic                     cfg_we,
  input  logic [CFG_INDEX_W-1:0]   cfg_addr,
  input  logic [BYTE_W-1:0]        cfg_wdata
);

  logic [BYTE_W-1:0] expected_code;
  logic [BYTE_W-1:0] payload_capacity;
  in_item_t          in_item;
  in_item_t          item;
  logic              item_valid;
  logic              take;
  logic              out_free;
  logic              res_valid;
  result_t           res;
  result_t           out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_code    <= EXPECTED_CODE_RESET;
      payload_capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_EXPECTED_CODE:    expected_code    <= cfg_wdata;
        REG_PAYLOAD_CAPACITY: payload_capacity <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_item.frame_start = s_tuser;
  assign in_item.rx_byte     = s_tdata;

  nfcrp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  nfcrp_parse u_parse (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item             (item),
    .out_free         (out_free),
    .expected_code    (expected_code),
    .payload_capacity (payload_capacity),
    .take             (take),
    .res_valid        (res_valid),
    .res              (res)
  );

  nfcrp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .load_res  (res),
    .out_free  (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = out_res.payload_byte;
  assign m_tuser = {out_res.status, out_res.has_data};
  assign m_tlast = out_res.last;

endmodule

### hdl/nfcrp_in_reg.sv
// ---------------------------------------------------------------------------
// NFC response frame parser input register
// Holds one received beat until the parse stage takes it.
// ---------------------------------------------------------------------------
module nfcrp_in_reg
  import nfcrp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     item_valid,
  output in_item_t item,
  input  logic     take
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

### hdl/nfcrp_parse.sv
// ---------------------------------------------------------------------------
// NFC response frame parser decode stage
// Tracks frame position, checks header, length, identifier and code,
// and forms at most one result per byte.
// ---------------------------------------------------------------------------
`include "nfc_response_frame_parser_macros.svh"

module nfcrp_parse
  import nfcrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  in_item_t          item,
  input  logic              out_free,
  input  logic [BYTE_W-1:0] expected_code,
  input  logic [BYTE_W-1:0] payload_capacity,
  output logic              take,
  output logic              res_valid,
  output result_t           res
);

  pos_t              pos, pos_next;
  logic [BYTE_W-1:0] frame_length, frame_length_next;
  logic [BYTE_W-1:0] remaining, remaining_next;
  logic              finished, finished_next;

  pos_t              eff_pos;
  logic [BYTE_W-1:0] eff_len;
  logic [BYTE_W-1:0] eff_rem;
  logic              eff_fin;
  logic [BYTE_W-1:0] plen;
  logic [BYTE_W-1:0] rem_dec;
  logic              done;

  assign eff_pos = item.frame_start ? POS_PRE0 : pos;
  assign eff_len = item.frame_start ? '0 : frame_length;
  assign eff_rem = item.frame_start ? '0 : remaining;
  assign eff_fin = item.frame_start ? 1'b0 : finished;
  assign plen    = eff_len - LEN_OVERHEAD;
  assign rem_dec = eff_rem - 8'd1;

  assign take = item_valid && (!res_valid || out_free);

  // results and frame end
  always_comb begin
    res_valid        = 1'b0;
    res.has_data     = 1'b0;
    res.payload_byte = '0;
    res.status       = ST_OK;
    res.last         = 1'b1;
    done             = 1'b0;
    if (item_valid && !eff_fin) begin
      unique case (eff_pos)
        POS_PRE0, POS_PRE1: begin
          if (item.rx_byte != HDR_ZERO) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_HEADER;
          end
        end
        POS_START: begin
          if (item.rx_byte != HDR_START) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_HEADER;
          end
        end
        POS_LEN: begin
        end
        POS_LCS: begin
          if (eff_len + item.rx_byte != '0) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_LCS;
          end
        end
        POS_TFI: begin
          if (item.rx_byte != FRAME_ID_RESPONSE) begin
            res_valid  = 1'b1;
            res.status = ST_UNEXPECTED;
          end
        end
        POS_CODE: begin
          if (item.rx_byte != expected_code) begin
            res_valid  = 1'b1;
            res.status = ST_UNEXPECTED;
          end else if (plen > payload_capacity) begin
            res_valid  = 1'b1;
            res.status = ST_TOO_LARGE;
          end else if (plen == '0) begin
            res_valid  = 1'b1;
            res.status = ST_OK;
          end
        end
        POS_DATA: begin
          if (eff_rem == '0) begin
            done = 1'b1;
          end else begin
            res_valid        = 1'b1;
            res.has_data     = 1'b1;
            res.payload_byte = item.rx_byte;
            res.last         = (rem_dec == '0);
          end
        end
        default: begin
        end
      endcase
    end
    if (res_valid && res.last) begin
      done = 1'b1;
    end
  end

  // next state
  always_comb begin
    pos_next          = pos;
    frame_length_next = eff_len;
    remaining_next    = eff_rem;
    finished_next     = eff_fin || done;
    if (eff_fin) begin
      pos_next = eff_pos;
    end else begin
      unique case (eff_pos)
        POS_PRE0:  pos_next = POS_PRE1;
        POS_PRE1:  pos_next = POS_START;
        POS_START: pos_next = POS_LEN;
        POS_LEN: begin
          pos_next          = POS_LCS;
          frame_length_next = item.rx_byte;
        end
        POS_LCS:   pos_next = POS_TFI;
        POS_TFI:   pos_next = POS_CODE;
        POS_CODE: begin
          pos_next = POS_DATA;
          if (!res_valid) begin
            remaining_next = plen;
          end
        end
        POS_DATA: begin
          pos_next = POS_DATA;
          if (eff_rem != '0) begin
            remaining_next = rem_dec;
          end
        end
        default:   pos_next = POS_PRE0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= POS_PRE0;
      frame_length <= '0;
      remaining    <= '0;
      finished     <= 1'b1;
    end else if (take) begin
      pos          <= pos_next;
      frame_length <= frame_length_next;
      remaining    <= remaining_next;
      finished     <= finished_next;
    end
  end

  `NFCRP_ASSERT_IMPL(a_data_is_ok, res_valid && res.has_data, res.status == ST_OK)
  `NFCRP_ASSERT_NEXT(a_finished_holds, finished && !(take && item.frame_start), finished)
  `NFCRP_ASSERT_NEXT(a_data_pos_holds, pos == POS_DATA && !(take && item.frame_start), pos == POS_DATA)
  `NFCRP_ASSERT_IMPL(a_data_needs_count, res_valid && res.has_data && !item.frame_start, remaining != '0)

endmodule

### hdl/nfcrp_out_reg.sv
// ---------------------------------------------------------------------------
// NFC response frame parser result register
// Holds one result beat until the downstream side takes it.
// ---------------------------------------------------------------------------
module nfcrp_out_reg
  import nfcrp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      out_res <= load_res;
    end
  end

endmodule
